### src/aewo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ADSR enveloped wave oscillator.
// No dependencies; used by aewo_div and the top level.
package aewo_pkg;

    localparam int DivQbW = 5;
    localparam logic [14:0] FullScale = 15'd32767;
    localparam logic [35:0] SusRecip = 36'd343586898;
    localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
    localparam logic [63:0] Q30One = 64'd1073741824;

    localparam logic [2:0] CfgAttack  = 3'd0;
    localparam logic [2:0] CfgDecay   = 3'd1;
    localparam logic [2:0] CfgSustain = 3'd2;
    localparam logic [2:0] CfgRelease = 3'd3;
    localparam logic [2:0] CfgHold    = 3'd4;
    localparam logic [2:0] CfgPeriod  = 3'd5;
    localparam logic [2:0] CfgShape   = 3'd6;

    localparam logic [1:0] WaveSquare   = 2'd0;
    localparam logic [1:0] WaveSaw      = 2'd1;
    localparam logic [1:0] WaveTriangle = 2'd2;
    localparam logic [1:0] WaveSine     = 2'd3;

    typedef struct packed {
        logic               start;
        logic [DivQbW-1:0]  qb;
    } t_div_req;

    // floor(pct * 32767 / 100) by a scaled reciprocal, exact for pct up to 100
    function automatic logic [14:0] f_sus_level(input logic [6:0] pct);
        logic [6:0]  p;
        logic [35:0] prod;
        p = (pct > 7'd100) ? 7'd100 : pct;
        prod = 36'(p) * SusRecip;
        return prod[34:20];
    endfunction

endpackage

### src/adsr_enveloped_wave_oscillator.sv
`timescale 1ns / 1ps
// ADSR enveloped wave oscillator: one signed 16-bit note sample per request.
// Depends on aewo_pkg and aewo_div.
//
// One request is worked on at a time. Its length is set by the bit-serial
// divider, which yields one quotient bit per cycle. Each request is accepted,
// then divides for its envelope (15 bits, skipped in sustain), its wave (saw
// 16 bits, triangle 17, none for square) and its scaling (15 bits), and is
// put out. Sine divides its phase by log2(SINE_TABLE_ENTRIES) + 2 bits, reads
// the table, interpolates with a division of 32 - log2(SINE_TABLE_ENTRIES)
// bits and scales the result. An idle or finished note goes straight to the
// output. A stalled output adds its wait. A finished sample sits in the output
// register while the next request is taken.
// SINE_TABLE_ENTRIES must be a power of two.
module adsr_enveloped_wave_oscillator import aewo_pkg::*; #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_note,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_sample,
    output logic        o_note_active,
    output logic        o_last_sample,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_data
);

    localparam int SineAw = $clog2(SINE_TABLE_ENTRIES);
    localparam int QuoW = 32 - SineAw;
    localparam int NumW = 48 - SineAw;
    localparam logic [SineAw:0] SineTop = (SineAw+1)'(SINE_TABLE_ENTRIES);

    typedef logic [30:0] t_sine_rom [0:SINE_TABLE_ENTRIES];

    function automatic t_sine_rom f_build_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
            x = (64'(i) * HalfPiQ30) / 64'(SINE_TABLE_ENTRIES);
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(Q30One)) begin
                sum = longint'(Q30One);
            end
            rom[i] = 31'(sum);
        end
        return rom;
    endfunction

    localparam t_sine_rom SineRom = f_build_rom();

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_ENV     = 12'b000000000010,
        S_ENV_W   = 12'b000000000100,
        S_WAVE    = 12'b000000001000,
        S_WAVE_W  = 12'b000000010000,
        S_ROM     = 12'b000000100000,
        S_INTERP  = 12'b000001000000,
        S_INT_W   = 12'b000010000000,
        S_SINE    = 12'b000100000000,
        S_SCALE   = 12'b001000000000,
        S_SCALE_W = 12'b010000000000,
        S_PUT     = 12'b100000000000
    } t_state;

    typedef enum logic [1:0] {
        EnvAttack  = 2'd0,
        EnvDecay   = 2'd1,
        EnvSustain = 2'd2,
        EnvRelease = 2'd3
    } t_env_sec;

    // configuration
    logic [19:0] r_attack, r_decay, r_release, r_hold;
    logic [6:0]  r_sus_pct;
    logic [15:0] r_period;
    logic [1:0]  r_shape;
    logic [14:0] r_sus;

    // note state
    logic [20:0] r_pos;
    logic [15:0] r_phase;
    logic        r_play;

    // work registers
    t_state      r_state;
    t_env_sec    r_sec;
    logic [20:0] r_p;
    logic [15:0] r_t;
    logic [15:0] r_per;
    logic        r_last;
    logic [14:0] r_env;
    logic [14:0] r_mag;
    logic        r_neg;
    logic [1:0]  r_quad;
    logic [15:0] r_frac;
    logic [SineAw:0] r_addr_a, r_addr_b;
    logic [30:0] r_rom_a, r_rom_b;
    logic [30:0] r_m;
    logic [15:0] r_samp;
    logic        r_act;

    // output register
    logic        r_ov;
    logic [15:0] r_out_samp;
    logic        r_out_act;
    logic        r_out_last;

    // divider
    t_div_req        div_req;
    logic [NumW-1:0] div_num;
    logic [19:0]     div_den;
    logic            div_busy;
    logic [QuoW-1:0] div_quo;
    logic [19:0]     div_rem;

    aewo_div #(
        .QUO_W(QuoW),
        .NUM_W(NumW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_busy (div_busy),
        .o_quo  (div_quo),
        .o_rem  (div_rem)
    );

    // request decode
    logic        accept;
    logic [20:0] total;
    logic [15:0] per_eff;
    logic [20:0] pos_eff;
    logic [15:0] phase_eff;
    logic        play_eff;
    logic        dead;

    // envelope section
    logic [20:0] ad_sum;
    logic [20:0] rel_start;
    logic [19:0] env_ma;
    logic [14:0] env_mb;
    logic [34:0] env_prod;
    t_env_sec    sec;

    // wave decode
    logic [16:0] wv;
    logic [SineAw+1:0] spos;
    logic [30:0] rom_diff;
    logic [45:0] sine_prod;
    logic        out_free;

    assign accept = (r_state == S_IDLE) && i_in_valid;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        total = {1'b0, r_hold} + {1'b0, r_release};
        per_eff = (r_period < 16'd2) ? 16'd2 : r_period;
        pos_eff = i_start_note ? 21'd0 : r_pos;
        phase_eff = i_start_note ? 16'd0 : r_phase;
        play_eff = i_start_note || r_play;
        dead = !play_eff || (pos_eff >= total);
    end

    always_comb begin
        ad_sum = {1'b0, r_attack} + {1'b0, r_decay};
        rel_start = ({1'b0, r_hold} > ad_sum) ? {1'b0, r_hold} : ad_sum;
        if (r_p < {1'b0, r_attack}) begin
            sec = EnvAttack;
            env_ma = r_p[19:0];
            env_mb = FullScale;
        end else if (r_p < ad_sum) begin
            sec = EnvDecay;
            env_ma = 20'(r_p - {1'b0, r_attack});
            env_mb = FullScale - r_sus;
        end else if (r_p < rel_start) begin
            sec = EnvSustain;
            env_ma = '0;
            env_mb = '0;
        end else begin
            sec = EnvRelease;
            env_ma = 20'(r_p - rel_start);
            env_mb = r_sus;
        end
        env_prod = 35'(env_ma) * 35'(env_mb);
    end

    always_comb begin
        wv = div_quo[16:0];
        spos = div_quo[SineAw+1:0];
        rom_diff = r_quad[0] ? (r_rom_a - r_rom_b) : (r_rom_b - r_rom_a);
        sine_prod = 46'(r_m) * 46'(FullScale);
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.qb = '0;
        div_num = '0;
        div_den = 20'(r_per);
        case (r_state)
            S_ENV: begin
                div_req.start = (sec != EnvSustain);
                div_req.qb = DivQbW'(15);
                div_num = NumW'(env_prod);
                case (sec)
                    EnvAttack:  div_den = r_attack;
                    EnvDecay:   div_den = r_decay;
                    default:    div_den = r_release;
                endcase
            end
            S_WAVE: begin
                div_req.start = (r_shape != WaveSquare);
                case (r_shape)
                    WaveSaw: begin
                        div_req.qb = DivQbW'(16);
                        div_num = (NumW'(r_t) << 16) - (NumW'(r_t) << 1);
                    end
                    WaveTriangle: begin
                        div_req.qb = DivQbW'(17);
                        div_num = (NumW'(r_t) << 17) - (NumW'(r_t) << 2);
                    end
                    default: begin
                        div_req.qb = DivQbW'(SineAw + 2);
                        div_num = NumW'(r_t) << (SineAw + 2);
                    end
                endcase
            end
            S_INTERP: begin
                div_req.start = 1'b1;
                div_req.qb = DivQbW'(QuoW);
                div_num = NumW'(rom_diff[QuoW-1:0]) * NumW'(r_frac);
            end
            S_SCALE: begin
                div_req.start = 1'b1;
                div_req.qb = DivQbW'(15);
                div_num = NumW'(30'(r_env) * 30'(r_mag));
                div_den = 20'(FullScale);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sus <= f_sus_level(r_sus_pct);
        r_rom_a <= SineRom[r_addr_a];
        r_rom_b <= SineRom[r_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack <= 20'd480;
            r_decay <= 20'd480;
            r_sus_pct <= 7'd50;
            r_release <= 20'd480;
            r_hold <= 20'd48000;
            r_period <= 16'd109;
            r_shape <= WaveSquare;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgAttack:  r_attack <= i_cfg_data;
                CfgDecay:   r_decay <= i_cfg_data;
                CfgSustain: r_sus_pct <= i_cfg_data[6:0];
                CfgRelease: r_release <= i_cfg_data;
                CfgHold:    r_hold <= i_cfg_data;
                CfgPeriod:  r_period <= i_cfg_data[15:0];
                CfgShape:   r_shape <= i_cfg_data[1:0];
                default:    r_shape <= r_shape;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos <= '0;
            r_phase <= '0;
            r_play <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_p <= pos_eff;
                        r_t <= (phase_eff >= per_eff) ? 16'd0 : phase_eff;
                        r_per <= per_eff;
                        r_last <= (pos_eff == total - 21'd1);
                        r_play <= play_eff;
                        r_pos <= pos_eff;
                        r_act <= !dead;
                        r_samp <= '0;
                        r_state <= dead ? S_PUT : S_ENV;
                    end
                end
                S_ENV: begin
                    r_sec <= sec;
                    r_env <= r_sus;
                    r_state <= (sec == EnvSustain) ? S_WAVE : S_ENV_W;
                end
                S_ENV_W: begin
                    if (!div_busy) begin
                        case (r_sec)
                            EnvAttack: r_env <= div_quo[14:0];
                            EnvDecay:  r_env <= FullScale - div_quo[14:0];
                            default:   r_env <= r_sus - div_quo[14:0];
                        endcase
                        r_state <= S_WAVE;
                    end
                end
                S_WAVE: begin
                    if (r_shape == WaveSquare) begin
                        r_mag <= FullScale;
                        r_neg <= (r_t >= (r_per >> 1));
                        r_state <= S_SCALE;
                    end else begin
                        r_state <= S_WAVE_W;
                    end
                end
                S_WAVE_W: begin
                    if (!div_busy) begin
                        case (r_shape)
                            WaveSaw: begin
                                r_neg <= (wv >= 17'd32767);
                                r_mag <= (wv >= 17'd32767) ? 15'(17'd65534 - wv)
                                                           : wv[14:0];
                                r_state <= S_SCALE;
                            end
                            WaveTriangle: begin
                                if (wv < 17'd32767) begin
                                    r_neg <= 1'b0;
                                    r_mag <= wv[14:0];
                                end else if (wv <= 17'd65534) begin
                                    r_neg <= 1'b0;
                                    r_mag <= 15'(17'd65534 - wv);
                                end else if (wv < 17'd98301) begin
                                    r_neg <= 1'b1;
                                    r_mag <= 15'(wv - 17'd65534);
                                end else begin
                                    r_neg <= 1'b1;
                                    r_mag <= 15'(17'd131068 - wv);
                                end
                                r_state <= S_SCALE;
                            end
                            default: begin
                                r_quad <= spos[SineAw+1:SineAw];
                                r_frac <= div_rem[15:0];
                                if (spos[SineAw]) begin
                                    r_addr_a <= SineTop - (SineAw+1)'(spos[SineAw-1:0]);
                                    r_addr_b <= SineTop - (SineAw+1)'(spos[SineAw-1:0])
                                                - (SineAw+1)'(1);
                                end else begin
                                    r_addr_a <= (SineAw+1)'(spos[SineAw-1:0]);
                                    r_addr_b <= (SineAw+1)'(spos[SineAw-1:0])
                                                + (SineAw+1)'(1);
                                end
                                r_state <= S_ROM;
                            end
                        endcase
                    end
                end
                S_ROM: begin
                    r_state <= S_INTERP;
                end
                S_INTERP: begin
                    r_state <= S_INT_W;
                end
                S_INT_W: begin
                    if (!div_busy) begin
                        r_m <= r_quad[0] ? (r_rom_a - 31'(div_quo))
                                         : (r_rom_a + 31'(div_quo));
                        r_state <= S_SINE;
                    end
                end
                S_SINE: begin
                    r_mag <= sine_prod[44:30];
                    r_neg <= r_quad[1];
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_SCALE_W;
                end
                S_SCALE_W: begin
                    if (!div_busy) begin
                        r_samp <= r_neg ? 16'(-{1'b0, div_quo[14:0]})
                                        : {1'b0, div_quo[14:0]};
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_out_samp <= r_samp;
                        r_out_act <= r_act;
                        r_out_last <= r_act && r_last;
                        if (r_act) begin
                            r_pos <= r_pos + 21'd1;
                            r_phase <= (r_t + 16'd1 == r_per) ? 16'd0 : r_t + 16'd1;
                        end else begin
                            r_play <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_sample = r_out_samp;
    assign o_note_active = r_out_act;
    assign o_last_sample = r_out_last;

endmodule

### src/aewo_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on aewo_pkg (t_div_req, DivQbW).
module aewo_div import aewo_pkg::*; #(
    parameter int QUO_W = 22,
    parameter int NUM_W = 38
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [NUM_W-1:0] i_num,
    input  logic [19:0]      i_den,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quo,
    output logic [19:0]      o_rem
);

    logic              r_busy;
    logic [DivQbW-1:0] r_cnt;
    logic [19:0]       r_rem;
    logic [19:0]       r_den;
    logic [QUO_W-1:0]  r_lo;
    logic [QUO_W-1:0]  r_quo;

    logic [NUM_W+QUO_W-1:0] wide;
    logic [21:0]            trial;
    logic                   ge;
    logic [19:0]            n_rem;

    always_comb begin
        wide = {i_num, QUO_W'(0)} >> i_req.qb;
        trial = {1'b0, r_rem, r_lo[QUO_W-1]} - {2'b0, r_den};
        ge = !trial[21];
        n_rem = ge ? trial[19:0] : {r_rem[18:0], r_lo[QUO_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt <= i_req.qb;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DivQbW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= wide[QUO_W+19:QUO_W];
            r_lo <= wide[QUO_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo <= {r_lo[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo = r_quo;
    assign o_rem = r_rem;

endmodule
